>>> design/frc_pkg.sv
// Package for the fragment reassembly checker.
// Holds the header layout, sizes, word types and codes used by every module.
// Depends on nothing.
package frc_pkg;

	localparam int MSG_DEPTH  = 4096;
	localparam int ADDR_LIMIT = 4096;
	localparam int CAP_MAX    = (MSG_DEPTH < ADDR_LIMIT) ? MSG_DEPTH : ADDR_LIMIT;

	localparam int CAP_W   = 13;
	localparam int ADDR_W  = 12;
	localparam int POS_W   = 24;
	localparam int SUM_W   = 32;
	localparam int CNT_W   = 16;
	localparam int DATA_W  = 8;
	localparam int FADDR_W = POS_W + 1;

	localparam logic [POS_W-1:0] HDR_LEN    = POS_W'(24);
	localparam logic [POS_W-1:0] POS_MAX    = '1;
	localparam logic [CNT_W-1:0] CNT_MAX    = '1;

	// First byte of each header field.
	localparam logic [POS_W-1:0] P_SRC_FIRST  = POS_W'(0);
	localparam logic [POS_W-1:0] P_DST_FIRST  = POS_W'(5);
	localparam logic [POS_W-1:0] P_OFF_FIRST  = POS_W'(12);
	localparam logic [POS_W-1:0] P_FLG_FIRST  = POS_W'(15);
	localparam logic [POS_W-1:0] P_LEN_FIRST  = POS_W'(17);
	localparam logic [POS_W-1:0] P_CHK_FIRST  = POS_W'(20);
	// Last byte of each header field.
	localparam logic [POS_W-1:0] P_SRC_LAST   = POS_W'(4);
	localparam logic [POS_W-1:0] P_DST_LAST   = POS_W'(9);
	localparam logic [POS_W-1:0] P_SPORT      = POS_W'(10);
	localparam logic [POS_W-1:0] P_DPORT      = POS_W'(11);
	localparam logic [POS_W-1:0] P_OFF_LAST   = POS_W'(14);
	localparam logic [POS_W-1:0] P_FLG_LAST   = POS_W'(16);
	localparam logic [POS_W-1:0] P_LEN_LAST   = POS_W'(19);
	localparam logic [POS_W-1:0] P_CHK_LAST   = POS_W'(23);

	typedef enum logic {
		OP_BYTE   = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef enum logic {
		KIND_WRITE  = 1'b0,
		KIND_REPORT = 1'b1
	} kind_t;

	typedef struct packed {
		op_t              op;
		logic [DATA_W-1:0] data;
		logic             start;
	} item_t;

	typedef struct packed {
		logic               in_payload;
		logic               sum_ok;
		logic               in_len;
		logic [FADDR_W-1:0] addr;
	} hdr_info_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  payloads;
		logic [ADDR_W-1:0] length;
	} result_t;

endpackage

>>> design/frc_item_if.sv
// Input channel of the fragment reassembly checker: one packet byte or finish per word.
// Depends on frc_pkg.
interface frc_item_if;
	import frc_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [DATA_W-1:0] data_byte;
	logic              packet_start;

	modport source (output valid, output operation, output data_byte, output packet_start,
		input ready);
	modport sink (input valid, input operation, input data_byte, input packet_start,
		output ready);
endinterface

>>> design/frc_result_if.sv
// Result channel of the fragment reassembly checker: one message write or report per word.
// Depends on frc_pkg.
interface frc_result_if;
	import frc_pkg::*;

	logic              valid;
	logic              ready;
	logic              result_kind;
	logic              write_enable;
	logic [ADDR_W-1:0] message_address;
	logic [DATA_W-1:0] message_byte;
	logic [CNT_W-1:0]  packet_count;
	logic [ADDR_W-1:0] message_length;

	modport source (output valid, output result_kind, output write_enable,
		output message_address, output message_byte, output packet_count,
		output message_length, input ready);
	modport sink (input valid, input result_kind, input write_enable,
		input message_address, input message_byte, input packet_count,
		input message_length, output ready);
endinterface

>>> design/fragment_reassembly_checker_unit.sv
// Top level of the fragment reassembly checker: input register, header tracker,
// payload writer and result register. Depends on frc_pkg, the two channel interfaces,
// frc_header and frc_writer.
//
//   channel   direction  word
//   pkt_in    sink       operation, data_byte, packet_start
//   res_out   source     result_kind, write_enable, message_address, message_byte,
//                        packet_count, message_length
//   cfg       write      cfg_we, cfg_wdata (message capacity)
//
// One word is taken per cycle while the result register is not held; the result of a
// word, if any, reaches the result register at the edge that moves the word out of the
// input register. Header tracking and the write decision run combinationally between
// those two registers. Reset clears all counters and packet state and sets the capacity
// to 4096. A held result keeps the input register from advancing; one more word can be
// accepted only while the input register is empty or advancing.
module fragment_reassembly_checker_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	frc_item_if.sink                  pkt_in,
	frc_result_if.source              res_out,
	input  logic                      cfg_we,
	input  logic [frc_pkg::CAP_W-1:0] cfg_wdata
);
	import frc_pkg::*;

	item_t     item_s1;
	logic      valid_s1;
	logic      adv;
	logic      step_byte, finish;
	hdr_info_t info;
	result_t   res;
	result_t   out_s2;
	logic      out_valid_s2;

	assign adv          = valid_s1 && (!out_valid_s2 || res_out.ready);
	assign pkt_in.ready = !valid_s1 || adv;
	assign step_byte    = adv && (item_s1.op == OP_BYTE);
	assign finish       = adv && (item_s1.op == OP_FINISH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_in.ready) begin
			valid_s1 <= pkt_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_in.ready && pkt_in.valid) begin
			item_s1.op    <= op_t'(pkt_in.operation);
			item_s1.data  <= pkt_in.data_byte;
			item_s1.start <= pkt_in.packet_start;
		end
	end

	frc_header u_header (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_byte (step_byte),
		.finish    (finish),
		.item      (item_s1),
		.info      (info)
	);

	frc_writer u_writer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step_byte (step_byte),
		.finish    (finish),
		.start     (item_s1.start),
		.data      (item_s1.data),
		.info      (info),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid_s2 <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_s2 <= res;
		end
	end

	assign res_out.valid            = out_valid_s2;
	assign res_out.result_kind      = out_s2.kind;
	assign res_out.write_enable     = out_s2.we;
	assign res_out.message_address  = out_s2.addr;
	assign res_out.message_byte     = out_s2.data;
	assign res_out.packet_count     = out_s2.payloads;
	assign res_out.message_length   = out_s2.length;
endmodule

>>> design/frc_header.sv
// Header tracker: byte position, field assembly, header sum and the stored fields.
// Depends on frc_pkg.
module frc_header (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_byte,
	input  logic              finish,
	input  frc_pkg::item_t    item,
	output frc_pkg::hdr_info_t info
);
	import frc_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d, p;
	logic [SUM_W-1:0] fs_q, fs_d, fs_new;
	logic [SUM_W-1:0] sum_q, sum_d;
	logic [POS_W-1:0] off_q, off_d;
	logic [POS_W-1:0] tl_q, tl_d;
	logic [SUM_W-1:0] chk_q, chk_d;

	always_comb begin
		p      = item.start ? '0 : pos_q;
		fs_new = {fs_q[SUM_W-DATA_W-1:0], item.data};
		if (p inside {P_SRC_FIRST, P_DST_FIRST, P_OFF_FIRST, P_FLG_FIRST, P_LEN_FIRST,
				P_CHK_FIRST}) begin
			fs_new = {{(SUM_W-DATA_W){1'b0}}, item.data};
		end
		pos_d = pos_q;
		fs_d  = fs_q;
		sum_d = sum_q;
		off_d = off_q;
		tl_d  = tl_q;
		chk_d = chk_q;
		if (finish) begin
			pos_d = '0;
			fs_d  = '0;
			sum_d = '0;
			off_d = '0;
			tl_d  = '0;
			chk_d = '0;
		end else if (step_byte) begin
			if (item.start) begin
				sum_d = '0;
				off_d = '0;
				tl_d  = '0;
				chk_d = '0;
			end
			if (p < HDR_LEN) begin
				fs_d = fs_new;
				case (p)
					P_SRC_LAST, P_DST_LAST, P_FLG_LAST: begin
						sum_d = sum_d + fs_new;
					end
					P_SPORT, P_DPORT: begin
						sum_d = sum_d + SUM_W'(item.data);
					end
					P_OFF_LAST: begin
						off_d = fs_new[POS_W-1:0];
						sum_d = sum_d + SUM_W'(fs_new[POS_W-1:0]);
					end
					P_LEN_LAST: begin
						tl_d  = fs_new[POS_W-1:0];
						sum_d = sum_d + SUM_W'(fs_new[POS_W-1:0]);
					end
					P_CHK_LAST: begin
						chk_d = fs_new;
					end
					default: begin
					end
				endcase
			end
			pos_d = (p == POS_MAX) ? p : p + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fs_q  <= '0;
			sum_q <= '0;
			off_q <= '0;
			tl_q  <= '0;
			chk_q <= '0;
		end else begin
			pos_q <= pos_d;
			fs_q  <= fs_d;
			sum_q <= sum_d;
			off_q <= off_d;
			tl_q  <= tl_d;
			chk_q <= chk_d;
		end
	end

	assign info.in_payload = !item.start && (pos_q >= HDR_LEN);
	assign info.sum_ok     = (chk_q == sum_q);
	assign info.in_len     = (pos_q < tl_q);
	assign info.addr       = FADDR_W'(off_q) + FADDR_W'(pos_q) - FADDR_W'(HDR_LEN);
endmodule

>>> design/frc_writer.sv
// Payload writer: capacity register, write decision, byte and packet counters.
// Depends on frc_pkg; takes the header status from frc_header.
module frc_writer (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [frc_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                     step_byte,
	input  logic                     finish,
	input  logic                     start,
	input  logic [frc_pkg::DATA_W-1:0] data,
	input  frc_pkg::hdr_info_t       info,
	output frc_pkg::result_t         res
);
	import frc_pkg::*;

	logic [ADDR_W-1:0] limit_q;
	logic [ADDR_W-1:0] written_q, written_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              wrote_q, wrote_d;
	logic              stopped_q, stopped_d;
	logic              try_write, blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ADDR_W'(CAP_MAX - 1);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				limit_q <= '0;
			end else if (cfg_wdata > CAP_W'(CAP_MAX)) begin
				limit_q <= ADDR_W'(CAP_MAX - 1);
			end else begin
				limit_q <= ADDR_W'(cfg_wdata - CAP_W'(1));
			end
		end
	end

	assign try_write = step_byte && info.in_payload && info.sum_ok && info.in_len && !stopped_q;
	assign blocked   = (written_q >= limit_q) || (info.addr >= FADDR_W'(limit_q));

	always_comb begin
		written_d = written_q;
		count_d   = count_q;
		wrote_d   = wrote_q;
		stopped_d = stopped_q;
		res       = '0;
		res.kind  = KIND_WRITE;
		if (finish) begin
			res.valid    = 1'b1;
			res.kind     = KIND_REPORT;
			res.we       = (count_q != '0);
			res.addr     = written_q;
			res.payloads = count_q;
			res.length   = written_q;
			written_d    = '0;
			count_d      = '0;
			wrote_d      = 1'b0;
			stopped_d    = 1'b0;
		end else if (step_byte && start) begin
			wrote_d   = 1'b0;
			stopped_d = 1'b0;
		end else if (try_write) begin
			if (blocked) begin
				stopped_d = 1'b1;
			end else begin
				written_d = written_q + ADDR_W'(1);
				if (!wrote_q) begin
					wrote_d = 1'b1;
					if (count_q != CNT_MAX) begin
						count_d = count_q + CNT_W'(1);
					end
				end
				res.valid    = 1'b1;
				res.we       = 1'b1;
				res.addr     = info.addr[ADDR_W-1:0];
				res.data     = data;
				res.payloads = count_d;
				res.length   = written_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			count_q   <= '0;
			wrote_q   <= 1'b0;
			stopped_q <= 1'b0;
		end else begin
			written_q <= written_d;
			count_q   <= count_d;
			wrote_q   <= wrote_d;
			stopped_q <= stopped_d;
		end
	end
endmodule

>>> design/frc_checker.sv
// Port checker for the fragment reassembly checker and its bind to the top level.
// Depends on frc_pkg and fragment_reassembly_checker_unit.
module frc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       result_kind,
	input logic                       write_enable,
	input logic [frc_pkg::ADDR_W-1:0] message_address,
	input logic [frc_pkg::DATA_W-1:0] message_byte,
	input logic [frc_pkg::CNT_W-1:0]  packet_count,
	input logic [frc_pkg::ADDR_W-1:0] message_length
);
	import frc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind)
			&& $stable(message_address) && $stable(message_byte)
			&& $stable(message_length))
		else $error("Result word changed while stalled.");

	a_write_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_WRITE) |-> write_enable
			&& (packet_count != '0) && (message_length != '0))
		else $error("Byte write without counted packet or length.");

	a_report_we: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_REPORT)
			|-> (write_enable == (packet_count != '0)) && (message_byte == '0)
			&& (message_address == message_length))
		else $error("Report word fields disagree.");

	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (result_kind == KIND_REPORT)
			##1 out_valid && (result_kind == KIND_WRITE)
			|-> (message_length == ADDR_W'(1)) && (packet_count == CNT_W'(1)))
		else $error("Counters not cleared by a report.");
endmodule

bind fragment_reassembly_checker_unit frc_checker u_frc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (res_out.valid),
	.out_ready        (res_out.ready),
	.result_kind      (res_out.result_kind),
	.write_enable     (res_out.write_enable),
	.message_address  (res_out.message_address),
	.message_byte     (res_out.message_byte),
	.packet_count     (res_out.packet_count),
	.message_length   (res_out.message_length)
);
